// ===== sv/ckd_pkg.sv =====
// shared constants and types of the chord keyboard detector
package ckd_pkg;

	localparam int NUM_SWITCHES = 32;
	localparam int MASK_W       = 32;
	localparam int IDX_W        = 6;
	localparam int DELAY_W      = 10;
	localparam int MODE_W       = 4;
	localparam int CFG_IDX_W    = 2;

	localparam logic [IDX_W-1:0] NONE_MARK = 6'd63;

	// running values of the update walk, handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] last_rel;
		logic             dtap;
		logic             any_press;
		logic             any_release;
	} ckd_token_t;

	// finishing command broadcast to every cell
	typedef struct packed {
		logic apply;
		logic promote;
		logic hold_req;
		logic send_chord;
	} ckd_cmd_t;

endpackage

// ===== sv/ckd_cell.sv =====
// one switch cell: two-bit status, walk step and finishing update
module ckd_cell
	import ckd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       closed,
	input  logic       hold_bit,
	input  ckd_token_t tok_in,
	output ckd_token_t tok_out,
	input  ckd_cmd_t   cmd,
	output logic       chord_bit,
	output logic       down
);

	logic lo_q;
	logic hi_q;
	ckd_token_t tok_q;
	ckd_token_t tok_d;
	logic lo_fin;
	logic hi_fin;

	assign down    = lo_q | hi_q;
	assign tok_out = tok_q;

	// promote, then hold request
	always_comb begin
		lo_fin = lo_q | (cmd.promote & hi_q);
		hi_fin = hi_q;
		if (cmd.hold_req && hold_bit && down) begin
			lo_fin = 1'b1;
			hi_fin = 1'b1;
		end
	end

	assign chord_bit = lo_fin;

	// token handed to the next cell
	always_comb begin
		tok_d     = tok_in;
		tok_d.idx = tok_in.idx + 1'b1;
		if (tok_in.valid) begin
			if (!down && closed) begin
				tok_d.any_press   = 1'b1;
				tok_d.dtap        = tok_in.dtap | (tok_in.idx == tok_in.last_rel);
				tok_d.last_rel    = NONE_MARK;
			end else if (down && !closed) begin
				tok_d.any_release = 1'b1;
				tok_d.last_rel    = tok_in.idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q        <= 1'b0;
			hi_q        <= 1'b0;
			tok_q       <= '0;
		end else begin
			tok_q       <= tok_d;
			if (tok_in.valid) begin
				if (!down && closed) begin
					lo_q              <= 1'b1;
					hi_q              <= 1'b0;
				end else if (down && !closed) begin
					lo_q              <= 1'b0;
					hi_q              <= 1'b0;
				end
			end else if (cmd.apply) begin
				if (cmd.send_chord) begin
					// pressed-only switches become already sent
					lo_q <= lo_fin & hi_fin;
					hi_q <= lo_fin | hi_fin;
				end else begin
					lo_q <= lo_fin;
					hi_q <= hi_fin;
				end
			end
		end
	end

endmodule

// ===== sv/chord_keyboard_detector_core.sv =====
// top level of the chord keyboard detector: cell row, timers and packet register
// Takes one finished matrix scan per input beat and gives at most one packet beat
// per scan. Each switch has a cell holding its status; on accepting a scan a token
// enters the first cell and moves one cell per clock, updating presses and releases
// in ascending switch order and tracking the last released switch for double taps.
// After the token leaves the last cell, the finishing state applies double tap,
// held timer, hold request and packet detection to all cells at once and ticks the
// timers. A scan passes the start register that launches the token, the walk across
// the cell row, the result register that collects the token and the finishing state.
// Input is ready again in the cycle after finishing, so the next scan is taken only
// once the last one is through. A finished packet waits in an output register, and
// the next scan is walked meanwhile; its finishing state waits only while that
// register is full and out_ready is low. Configuration is to be written by the user
// through cfg_we / cfg_index / cfg_data only while idle; the block does not check.
module chord_keyboard_detector_core
	import ckd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DELAY_W-1:0]   cfg_data,
	// scan input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MASK_W-1:0]    pressed_mask,
	input  logic                 hold_valid,
	input  logic [MASK_W-1:0]    hold_mask,
	// packet output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 packet_valid,
	output logic                 partial_release,
	output logic [MASK_W-1:0]    chord_mask,
	output logic [MODE_W-1:0]    packet_mode
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} ckd_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAMING = 2'd0,
		CFG_MODE   = 2'd1,
		CFG_CHORD  = 2'd2,
		CFG_HELD   = 2'd3
	} ckd_cfg_t;

	localparam int TMR_CHORD   = 0;
	localparam int TMR_RELEASE = 1;
	localparam int TMR_HELD    = 2;
	localparam int NUM_TMR     = 3;

	// configuration registers
	logic               gaming_q;
	logic [MODE_W-1:0]  mode_q;
	logic [DELAY_W-1:0] chord_dly_q;
	logic [DELAY_W-1:0] held_dly_q;

	// control and timer state
	ckd_state_t          state_q;
	logic                start_q;
	logic [IDX_W-1:0]    last_rel_q;
	logic [NUM_TMR-1:0]  armed_q;
	logic [DELAY_W-1:0]  cnt_q [NUM_TMR];
	ckd_token_t          res_q;

	// captured scan
	logic [MASK_W-1:0] scan_mask_q;
	logic [MASK_W-1:0] hold_mask_q;
	logic              hold_req_q;

	// packet register
	logic              out_valid_q;
	logic              partial_q;
	logic [MASK_W-1:0] chord_q;
	logic [MODE_W-1:0] pmode_q;

	// cell row
	ckd_token_t              tok [NUM_SWITCHES+1];
	ckd_cmd_t                cmd;
	logic [NUM_SWITCHES-1:0] chord_vec;
	logic [NUM_SWITCHES-1:0] down_vec;
	logic [MASK_W-1:0]       chord_word;

	// finishing logic
	logic                finish_go;
	logic [NUM_TMR-1:0]  start_v;
	logic [NUM_TMR-1:0]  armed_eff;
	logic [NUM_TMR-1:0]  armed_fin;
	logic [DELAY_W-1:0]  cnt_eff [NUM_TMR];
	logic [DELAY_W-1:0]  cnt_fin [NUM_TMR];
	logic [DELAY_W-1:0]  dly_chord;
	logic [DELAY_W-1:0]  dly_held;
	logic                fire_held;
	logic                fire_chord;
	logic                fire_rel;
	logic                send_chord;
	logic                send_rel;

	assign in_ready  = (state_q == ST_IDLE);
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	// token enters the first cell in the cycle after the scan beat
	always_comb begin
		tok[0]          = '0;
		tok[0].valid    = start_q;
		tok[0].last_rel = last_rel_q;
	end

	assign cmd.apply      = finish_go;
	assign cmd.promote    = res_q.dtap | fire_held;
	assign cmd.hold_req   = hold_req_q;
	assign cmd.send_chord = send_chord;

	for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_cell
		logic closed_b;
		logic hold_b;
		if (i < MASK_W) begin : g_in
			assign closed_b = scan_mask_q[i];
			assign hold_b   = hold_mask_q[i];
		end else begin : g_none
			// switches beyond the input width read open and cannot be held
			assign closed_b = 1'b0;
			assign hold_b   = 1'b0;
		end
		ckd_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.closed    (closed_b),
			.hold_bit  (hold_b),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.cmd       (cmd),
			.chord_bit (chord_vec[i]),
			.down      (down_vec[i])
		);
	end

	// chord bits beyond the output width are dropped
	for (genvar b = 0; b < MASK_W; b++) begin : g_chord
		if (b < NUM_SWITCHES) begin : g_bit
			assign chord_word[b] = chord_vec[b];
		end else begin : g_zero
			assign chord_word[b] = 1'b0;
		end
	end

	// timer starts, held check, chord/release check and tick
	always_comb begin
		dly_chord = gaming_q ? '0 : chord_dly_q;
		dly_held  = gaming_q ? '0 : held_dly_q;
		start_v[TMR_CHORD]   = res_q.any_press;
		start_v[TMR_RELEASE] = res_q.any_release;
		start_v[TMR_HELD]    = res_q.any_press | res_q.any_release;
		cnt_eff[TMR_CHORD]   = start_v[TMR_CHORD] ? dly_chord : cnt_q[TMR_CHORD];
		cnt_eff[TMR_RELEASE] = start_v[TMR_RELEASE] ? dly_chord : cnt_q[TMR_RELEASE];
		cnt_eff[TMR_HELD]    = start_v[TMR_HELD] ? dly_held : cnt_q[TMR_HELD];
		armed_eff = armed_q | start_v;

		fire_held  = armed_eff[TMR_HELD] && (cnt_eff[TMR_HELD] == '0);
		fire_chord = armed_eff[TMR_CHORD] && (cnt_eff[TMR_CHORD] == '0);
		fire_rel   = armed_eff[TMR_RELEASE] && (cnt_eff[TMR_RELEASE] == '0);

		// gaming: a fired release also sends a chord and both fired timers disarm
		send_chord = fire_chord | (gaming_q & fire_rel);
		send_rel   = !send_chord && fire_rel;

		armed_fin = armed_eff;
		if (fire_held) begin
			armed_fin[TMR_HELD] = 1'b0;
		end
		if (fire_chord) begin
			armed_fin[TMR_CHORD] = 1'b0;
		end
		if (fire_rel && (gaming_q || !fire_chord)) begin
			armed_fin[TMR_RELEASE] = 1'b0;
		end

		for (int t = 0; t < NUM_TMR; t++) begin
			cnt_fin[t] = cnt_eff[t];
			if (armed_fin[t] && (cnt_eff[t] != '0)) begin
				cnt_fin[t] = cnt_eff[t] - 1'b1;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gaming_q    <= 1'b0;
			mode_q      <= '0;
			chord_dly_q <= 10'd20;
			held_dly_q  <= 10'd200;
		end else if (cfg_we) begin
			case (ckd_cfg_t'(cfg_index))
				CFG_GAMING: gaming_q    <= cfg_data[0];
				CFG_MODE:   mode_q      <= cfg_data[MODE_W-1:0];
				CFG_CHORD:  chord_dly_q <= cfg_data;
				CFG_HELD:   held_dly_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// sequencing and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			last_rel_q <= NONE_MARK;
			armed_q    <= '0;
			res_q      <= '0;
			for (int t = 0; t < NUM_TMR; t++) begin
				cnt_q[t] <= '0;
			end
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						start_q <= 1'b1;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (tok[NUM_SWITCHES].valid) begin
						res_q   <= tok[NUM_SWITCHES];
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						last_rel_q <= res_q.last_rel;
						armed_q    <= armed_fin;
						for (int t = 0; t < NUM_TMR; t++) begin
							cnt_q[t] <= cnt_fin[t];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// scan capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			scan_mask_q <= pressed_mask;
			hold_mask_q <= hold_mask;
			hold_req_q  <= hold_valid;
		end
	end

	// packet register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go && (send_chord || send_rel)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go && (send_chord || send_rel)) begin
			partial_q <= send_rel & (|down_vec);
			chord_q   <= send_chord ? chord_word : '0;
			pmode_q   <= mode_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign packet_valid    = 1'b1;
	assign partial_release = partial_q;
	assign chord_mask      = chord_q;
	assign packet_mode     = pmode_q;

endmodule
